// File: rtl/i2ctes_pkg.sv
// Shared types and codes for the I2C target event sequencer.
// Used by the controller, the datapath and the top level; no dependencies.
package i2ctes_pkg;

  // number of pending flags in one interrupt snapshot
  localparam int unsigned FLAG_W = 5;

  // flag bit positions inside the snapshot
  localparam int unsigned FB_ABRT  = 0;
  localparam int unsigned FB_START = 1;
  localparam int unsigned FB_RX    = 2;
  localparam int unsigned FB_RDREQ = 3;
  localparam int unsigned FB_STOP  = 4;

  // action codes of a result item
  typedef enum logic [3:0] {
    ACT_CLR_START   = 4'd0,
    ACT_CLR_ABORT   = 4'd1,
    ACT_DELIVER_RX  = 4'd2,
    ACT_SERVE_RD    = 4'd3,
    ACT_STOP_FINISH = 4'd4,
    ACT_DISCARD_RX  = 4'd5,
    ACT_RD_SEND_FF  = 4'd6,
    ACT_STOP_ONLY   = 4'd7,
    ACT_NONE        = 4'd8
  } action_t;

  // transfer phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STARTED = 2'd1,
    PH_WRITE   = 2'd2,
    PH_READ    = 2'd3
  } phase_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new snapshot
    logic emit_none;   // emit the no-action result for an empty snapshot
    logic step_main;   // one step of the phase machine
    logic step_clean;  // one step of the error cleanup
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_valid;   // output register holds a result
    logic in_empty;    // incoming snapshot has no flag set
    logic main_err;    // phase machine hits an unexpected flag
    logic main_done;   // no flag left after the phase step
    logic clean_done;  // no flag left after the cleanup step
  } dp_status_t;

endpackage

// File: rtl/i2ctes_datapath.sv
// Datapath of the I2C target event sequencer: snapshot flags, transfer phase,
// per-step priority logic and the output register. Depends on i2ctes_pkg.
module i2ctes_datapath import i2ctes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [FLAG_W-1:0] flags_in,
  input  logic              out_ready,
  output dp_status_t        st,
  output logic              out_valid,
  output logic [3:0]        action,
  output logic              error_path,
  output logic              busy_res,
  output logic              last
);

  logic [FLAG_W-1:0] flags;
  phase_t            phase;
  action_t           act_reg;

  // phase machine step
  logic [FLAG_W-1:0] m_flags;
  phase_t            m_phase;
  action_t           m_act;
  logic              m_emit;
  logic              m_err;

  // cleanup step
  logic [FLAG_W-1:0] c_flags;
  action_t           c_act;

  logic emit;

  // one step of the phase machine, highest priority flag for the phase
  always_comb begin
    m_flags = flags;
    m_phase = phase;
    m_act   = ACT_NONE;
    m_emit  = 1'b0;
    m_err   = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (flags[FB_START]) begin
          m_flags[FB_START] = 1'b0;
          m_phase = PH_STARTED;
          m_act   = ACT_CLR_START;
          m_emit  = 1'b1;
        end else if (flags[FB_ABRT]) begin
          m_flags[FB_ABRT] = 1'b0;
          m_act  = ACT_CLR_ABORT;
          m_emit = 1'b1;
        end else begin
          m_err = 1'b1;
        end
      end
      PH_STARTED: begin
        if (flags[FB_RX]) begin
          m_phase = PH_WRITE;
        end else if (flags[FB_RDREQ]) begin
          m_phase = PH_READ;
        end else begin
          m_err = 1'b1;
        end
      end
      PH_WRITE: begin
        if (flags[FB_RX]) begin
          m_flags[FB_RX] = 1'b0;
          m_act  = ACT_DELIVER_RX;
          m_emit = 1'b1;
        end else if (flags[FB_STOP]) begin
          m_flags[FB_STOP] = 1'b0;
          m_phase = PH_IDLE;
          m_act   = ACT_STOP_FINISH;
          m_emit  = 1'b1;
        end else if (flags[FB_START]) begin
          m_flags[FB_START] = 1'b0;
          m_phase = PH_READ;
          m_act   = ACT_CLR_START;
          m_emit  = 1'b1;
        end else if (flags[FB_RDREQ]) begin
          m_phase = PH_READ;
        end else begin
          m_err = 1'b1;
        end
      end
      PH_READ: begin
        if (flags[FB_RDREQ]) begin
          m_flags[FB_RDREQ] = 1'b0;
          m_act  = ACT_SERVE_RD;
          m_emit = 1'b1;
        end else if (flags[FB_STOP]) begin
          m_flags[FB_STOP] = 1'b0;
          m_phase = PH_IDLE;
          m_act   = ACT_STOP_FINISH;
          m_emit  = 1'b1;
        end else begin
          m_err = 1'b1;
        end
      end
      default: begin
        m_err = 1'b1;
      end
    endcase
  end

  // one cleanup action per remaining flag, fixed order
  always_comb begin
    c_flags = flags;
    c_act   = ACT_STOP_ONLY;
    if (flags[FB_ABRT]) begin
      c_flags[FB_ABRT] = 1'b0;
      c_act = ACT_CLR_ABORT;
    end else if (flags[FB_START]) begin
      c_flags[FB_START] = 1'b0;
      c_act = ACT_CLR_START;
    end else if (flags[FB_RX]) begin
      c_flags[FB_RX] = 1'b0;
      c_act = ACT_DISCARD_RX;
    end else if (flags[FB_RDREQ]) begin
      c_flags[FB_RDREQ] = 1'b0;
      c_act = ACT_RD_SEND_FF;
    end else begin
      c_flags[FB_STOP] = 1'b0;
      c_act = ACT_STOP_ONLY;
    end
  end

  assign emit = cmd.emit_none | (cmd.step_main & m_emit) | cmd.step_clean;

  // control state: phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit | (out_valid & ~out_ready);
      if (cmd.step_main) begin
        phase <= m_err ? PH_IDLE : m_phase;
      end
    end
  end

  // snapshot flags and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flags <= flags_in;
    end else if (cmd.step_main) begin
      flags <= m_flags;
    end else if (cmd.step_clean) begin
      flags <= c_flags;
    end

    if (cmd.emit_none) begin
      act_reg    <= ACT_NONE;
      error_path <= 1'b0;
      busy_res   <= (phase != PH_IDLE);
      last       <= 1'b1;
    end else if (cmd.step_main && m_emit) begin
      act_reg    <= m_act;
      error_path <= 1'b0;
      busy_res   <= (m_phase != PH_IDLE);
      last       <= (m_flags == '0);
    end else if (cmd.step_clean) begin
      act_reg    <= c_act;
      error_path <= 1'b1;
      busy_res   <= 1'b0;
      last       <= (c_flags == '0);
    end
  end

  assign action = act_reg;

  // status back to the controller
  assign st.out_valid  = out_valid;
  assign st.in_empty   = (flags_in == '0);
  assign st.main_err   = m_err;
  assign st.main_done  = (m_flags == '0);
  assign st.clean_done = (c_flags == '0);

endmodule

// File: rtl/i2ctes_ctrl.sv
// Controller of the I2C target event sequencer: sequences the phase steps
// and the error cleanup, one step per cycle while the output register is free or taken. Depends on i2ctes_pkg.
module i2ctes_ctrl import i2ctes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_CLEAN = 3'b100
  } state_t;

  state_t state, state_next;
  logic   can_emit;
  logic   in_acc;

  // a new result may be written when the output register is free or leaving
  assign can_emit = ~st.out_valid | out_ready;
  assign in_ready = (state == S_IDLE) & can_emit;
  assign in_acc   = in_valid & in_ready;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.emit_none  = 1'b0;
    cmd.step_main  = 1'b0;
    cmd.step_clean = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (st.in_empty) begin
            cmd.emit_none = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_emit) begin
          cmd.step_main = 1'b1;
          if (st.main_err) begin
            state_next = S_CLEAN;
          end else if (st.main_done) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLEAN: begin
        if (can_emit) begin
          cmd.step_clean = 1'b1;
          if (st.clean_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/i2c_target_event_sequencer_unit.sv
// Top level of the I2C target event sequencer: controller plus datapath.
// Depends on i2ctes_pkg, i2ctes_ctrl and i2ctes_datapath.
//
// Takes one interrupt snapshot (five pending flags) per input item and
// returns between one and five result items, each an action code with its
// error-path, busy and last marks; last is set on the final result of the
// snapshot. The controller runs one step of the phase machine or of the
// error cleanup per clock, so a snapshot occupies the block while it is
// accepted and then for each of its steps: phase steps (actions and phase
// moves without action), or phase steps up to an unexpected flag, an
// error detect step and then one cleanup step per flag still pending. That
// is at most eight steps. An empty snapshot finishes in
// its accept cycle. Steps wait while the single output register is full and
// not taken, and a new snapshot is taken only after the last step of the
// previous one. The phase resets to idle.
module i2c_target_event_sequencer_unit import i2ctes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       abort_pending,
  input  logic       start_detected,
  input  logic       rx_data_ready,
  input  logic       read_requested,
  input  logic       stop_detected,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] action,
  output logic       error_path,
  output logic       busy_res,
  output logic       last
);

  dp_cmd_t           cmd;
  dp_status_t        st;
  logic [FLAG_W-1:0] flags_in;

  // pack the snapshot flags
  always_comb begin
    flags_in           = '0;
    flags_in[FB_ABRT]  = abort_pending;
    flags_in[FB_START] = start_detected;
    flags_in[FB_RX]    = rx_data_ready;
    flags_in[FB_RDREQ] = read_requested;
    flags_in[FB_STOP]  = stop_detected;
  end

  i2ctes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  i2ctes_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .flags_in   (flags_in),
    .out_ready  (out_ready),
    .st         (st),
    .out_valid  (out_valid),
    .action     (action),
    .error_path (error_path),
    .busy_res   (busy_res),
    .last       (last)
  );

endmodule

// File: rtl/i2ctes_checker.sv
// Port-level checks for the I2C target event sequencer, bound to the top level.
// Depends on i2ctes_pkg and i2c_target_event_sequencer_unit.
module i2ctes_checker import i2ctes_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] action,
  input logic       error_path,
  input logic       busy_res,
  input logic       last
);

  // a pending item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(last))
    else $error("output item changed while stalled");

  // cleanup items always leave the phase idle
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_path |-> !busy_res)
    else $error("error cleanup item reports busy");

  // the no-action item stands alone and is never part of cleanup
  a_none_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_NONE |-> last && !error_path)
    else $error("no-action item not alone");

  // only cleanup codes appear on the error path
  a_err_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_path |->
      action == ACT_CLR_ABORT || action == ACT_CLR_START ||
      action == ACT_DISCARD_RX || action == ACT_RD_SEND_FF ||
      action == ACT_STOP_ONLY)
    else $error("bad action code on error path");

  // a finishing stop always ends the transfer
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_STOP_FINISH |-> !busy_res && !error_path)
    else $error("stop finish with busy phase");

endmodule

bind i2c_target_event_sequencer_unit i2ctes_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .action     (action),
  .error_path (error_path),
  .busy_res   (busy_res),
  .last       (last)
);
